[design/srpaw_pkg.sv]
// Package for the sliced raw pixel address walker.
// Shared widths, constants, register indexes and the configuration status struct.
// No dependencies.
`timescale 1ns / 1ps

package srpaw_pkg;

  localparam int DIM_W       = 14;
  localparam int START_W     = 16;
  localparam int PIX_W       = 16;
  localparam int ADDR_W      = 26;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int SIDX_W      = 3;
  localparam int CNT_W       = 3;
  localparam int IDX_W       = 3;
  localparam int WIDTH_REGS  = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [ADDR_W-1:0] ADDR_MAX  = {ADDR_W{1'b1}};
  localparam logic [7:0]        BYTE_MASK = 8'hff;

  typedef enum logic [IDX_W-1:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_SLICE_COUNT   = 3'd2,
    REG_SLICE_WIDTH_0 = 3'd3,
    REG_SLICE_WIDTH_1 = 3'd4,
    REG_SLICE_WIDTH_2 = 3'd5,
    REG_SLICE_WIDTH_3 = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic                reload;
    logic [CNT_W-1:0]    count_eff;
    logic [DIM_W-1:0]    w_clamp;
    logic [DIM_W-1:0]    h_clamp;
    logic [AREA_W-1:0]   area;
  } cfg_t;

endpackage

[design/srpaw_if.sv]
// Valid/ready channel interfaces for pixel beats in and address beats out.
// Depends on srpaw_pkg.
`timescale 1ns / 1ps

interface srpaw_in_if;
  import srpaw_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_value;
  logic             frame_start;

  modport source (output valid, output pixel_value, output frame_start, input ready);
  modport sink   (input valid, input pixel_value, input frame_start, output ready);
endinterface

interface srpaw_out_if;
  import srpaw_pkg::*;
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] pixel_address;
  logic [7:0]        low_byte;
  logic [7:0]        high_byte;
  logic              out_of_bounds;

  modport source (output valid, output pixel_address, output low_byte, output high_byte,
                  output out_of_bounds, input ready);
  modport sink   (input valid, input pixel_address, input low_byte, input high_byte,
                  input out_of_bounds, output ready);
endinterface

[design/srpaw_cfg.sv]
// Configuration register file: clamped dimensions, effective slice count, frame area.
// Depends on srpaw_pkg.
`timescale 1ns / 1ps

module srpaw_cfg #(
  parameter int MAX_SLICES = 4,
  parameter int DIM_BITS   = 13
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [srpaw_pkg::IDX_W-1:0]            cfg_idx_i,
  input  logic [srpaw_pkg::DIM_W-1:0]            cfg_wdata_i,
  output srpaw_pkg::cfg_t                        cfg_o,
  output logic [MAX_SLICES-1:0][srpaw_pkg::DIM_W-1:0] widths_o
);
  import srpaw_pkg::*;

  localparam logic [16:0] DIM_LIMIT = 17'(1) << DIM_BITS;

  logic [DIM_W-1:0]  width_q, height_q;
  logic [CNT_W-1:0]  count_q;
  logic [MAX_SLICES-1:0][DIM_W-1:0] widths_q;
  logic              reload_q;
  logic [AREA_W-1:0] area_q;
  logic [DIM_W-1:0]  w_clamp, h_clamp;
  logic [CNT_W-1:0]  count_eff;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (17'(v) > DIM_LIMIT) begin
      r = DIM_LIMIT[DIM_W-1:0];
    end else begin
      r = v;
    end
    return r;
  endfunction

  assign w_clamp   = clamp_dim(width_q);
  assign h_clamp   = clamp_dim(height_q);
  assign count_eff = (4'(count_q) > 4'(MAX_SLICES)) ? CNT_W'(MAX_SLICES) : count_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= DIM_W'(1);
      height_q <= DIM_W'(1);
      count_q  <= '0;
      widths_q <= '0;
      reload_q <= 1'b0;
      area_q   <= AREA_W'(1);
    end else begin
      reload_q <= 1'b0;
      area_q   <= AREA_W'(w_clamp) * AREA_W'(h_clamp);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_IMAGE_WIDTH: begin
            width_q  <= cfg_wdata_i;
            reload_q <= 1'b1;
          end
          REG_IMAGE_HEIGHT: begin
            height_q <= cfg_wdata_i;
          end
          REG_SLICE_COUNT: begin
            count_q  <= cfg_wdata_i[CNT_W-1:0];
            reload_q <= 1'b1;
          end
          REG_SLICE_WIDTH_0: begin
            reload_q <= 1'b1;
          end
          default: begin
          end
        endcase
        for (int k = 0; k < MAX_SLICES; k++) begin
          if (k < WIDTH_REGS && int'(cfg_idx_i) == int'(REG_SLICE_WIDTH_0) + k) begin
            widths_q[k] <= cfg_wdata_i;
          end
        end
      end
    end
  end

  assign cfg_o.reload    = reload_q;
  assign cfg_o.count_eff = count_eff;
  assign cfg_o.w_clamp   = w_clamp;
  assign cfg_o.h_clamp   = h_clamp;
  assign cfg_o.area      = area_q;
  assign widths_o        = widths_q;

endmodule

[design/srpaw_front.sv]
// Front end: accepts pixel beats, walks the slice/row/column cursor, pushes work items.
// Depends on srpaw_pkg and srpaw_if.
`timescale 1ns / 1ps

module srpaw_front #(
  parameter int MAX_SLICES = 4,
  parameter int ROW_W      = 13,
  parameter int ITEM_W     = 73
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  srpaw_pkg::cfg_t                        cfg_i,
  input  logic [MAX_SLICES-1:0][srpaw_pkg::DIM_W-1:0] widths_i,
  srpaw_in_if.sink                               pix_i,
  output logic                                   push_valid_o,
  input  logic                                   push_ready_i,
  output logic [ITEM_W-1:0]                      push_data_o
);
  import srpaw_pkg::*;

  logic [ROW_W-1:0]   row_q, row_d, row_e;
  logic [DIM_W-1:0]   col_q, col_d, col_e;
  logic [SIDX_W-1:0]  sidx_q, sidx_d, sidx_e, sidx_n;
  logic [START_W-1:0] start_q, start_d, start_e, start_n;
  logic [DIM_W-1:0]   curw_q, curw_d, curw_e, curw_n;
  logic [DIM_W-1:0]   bw_q, bw_d;
  logic [DIM_W-1:0]   first_w, w_cur, w_nxt;
  logic [DIM_W:0]     col_inc;
  logic [ROW_W:0]     row_inc;
  logic               wrap_col, wrap_row, adv, accept;

  assign pix_i.ready  = push_ready_i && !cfg_i.reload;
  assign accept       = pix_i.valid && pix_i.ready;
  assign push_valid_o = accept;

  assign first_w = (cfg_i.count_eff != '0) ? widths_i[0] : cfg_i.w_clamp;

  always_comb begin
    if (pix_i.frame_start) begin
      row_e   = '0;
      col_e   = '0;
      sidx_e  = '0;
      start_e = '0;
      curw_e  = first_w;
    end else begin
      row_e   = row_q;
      col_e   = col_q;
      sidx_e  = sidx_q;
      start_e = start_q;
      curw_e  = curw_q;
    end
  end

  assign push_data_o = {pix_i.pixel_value, row_e, bw_q, start_e, col_e};

  assign col_inc  = (DIM_W+1)'(col_e) + (DIM_W+1)'(1);
  assign wrap_col = col_inc >= (DIM_W+1)'(curw_e);
  assign row_inc  = (ROW_W+1)'(row_e) + (ROW_W+1)'(1);
  assign wrap_row = (DIM_W+1)'(row_inc) >= (DIM_W+1)'(cfg_i.h_clamp);
  assign adv      = sidx_e < SIDX_W'(cfg_i.count_eff);
  assign sidx_n   = adv ? sidx_e + SIDX_W'(1) : sidx_e;

  always_comb begin
    w_cur = '0;
    w_nxt = '0;
    for (int k = 0; k < MAX_SLICES; k++) begin
      if (sidx_e == SIDX_W'(k)) begin
        w_cur = widths_i[k];
      end
      if (sidx_n == SIDX_W'(k)) begin
        w_nxt = widths_i[k];
      end
    end
  end

  assign start_n = adv ? start_e + START_W'(w_cur) : start_e;
  assign curw_n  = (sidx_n < SIDX_W'(cfg_i.count_eff)) ? w_nxt : '0;

  always_comb begin
    row_d   = row_q;
    col_d   = col_q;
    sidx_d  = sidx_q;
    start_d = start_q;
    curw_d  = curw_q;
    bw_d    = bw_q;
    if (accept) begin
      row_d   = row_e;
      sidx_d  = sidx_e;
      start_d = start_e;
      curw_d  = curw_e;
      if (wrap_col) begin
        col_d = '0;
        bw_d  = cfg_i.w_clamp;
        if (wrap_row) begin
          row_d   = '0;
          sidx_d  = sidx_n;
          start_d = start_n;
          curw_d  = curw_n;
        end else begin
          row_d = row_inc[ROW_W-1:0];
        end
      end else begin
        col_d = col_inc[DIM_W-1:0];
      end
    end else if (cfg_i.reload) begin
      curw_d = first_w;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q   <= '0;
      col_q   <= '0;
      sidx_q  <= '0;
      start_q <= '0;
      curw_q  <= DIM_W'(1);
      bw_q    <= DIM_W'(1);
    end else begin
      row_q   <= row_d;
      col_q   <= col_d;
      sidx_q  <= sidx_d;
      start_q <= start_d;
      curw_q  <= curw_d;
      bw_q    <= bw_d;
    end
  end

endmodule

[design/srpaw_queue.sv]
// Small FIFO between the cursor front end and the address back end.
// Depends on srpaw_pkg.
`timescale 1ns / 1ps

module srpaw_queue #(
  parameter int WIDTH = 73,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);
  import srpaw_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [PTR_W:0]   cnt_q;
  logic             push, pop;

  assign push_ready_o = cnt_q != (PTR_W+1)'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_data_o   = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + (PTR_W+1)'(1);
        2'b01:   cnt_q <= cnt_q - (PTR_W+1)'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

[design/srpaw_back.sv]
// Back end: row base multiply, saturation, column add and bounds check, output register.
// Depends on srpaw_pkg and srpaw_if.
`timescale 1ns / 1ps

module srpaw_back #(
  parameter int ROW_W  = 13,
  parameter int ITEM_W = 73
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  srpaw_pkg::cfg_t   cfg_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  logic [ITEM_W-1:0] pop_data_i,
  srpaw_out_if.source       res_o
);
  import srpaw_pkg::*;

  localparam int PROD_W = ROW_W + DIM_W;
  localparam int SUM_W  = (PROD_W > ADDR_W) ? PROD_W + 1 : ADDR_W + 1;

  logic [PIX_W-1:0]   in_pix;
  logic [ROW_W-1:0]   in_row;
  logic [DIM_W-1:0]   in_bw, in_col;
  logic [START_W-1:0] in_start;

  logic               s1_v_q, s2_v_q, out_v_q;
  logic               en1, en2, en3;
  logic [PROD_W-1:0]  prod_q;
  logic [START_W-1:0] s1_start_q;
  logic [DIM_W-1:0]   s1_col_q, s2_col_q;
  logic [PIX_W-1:0]   s1_pix_q, s2_pix_q, out_pix_q;
  logic [ADDR_W-1:0]  base_q, addr_q;
  logic               oob_q;
  logic [SUM_W-1:0]   sum;
  logic [ADDR_W-1:0]  base_d, addr_d;
  logic [ADDR_W:0]    addr_raw;

  assign {in_pix, in_row, in_bw, in_start, in_col} = pop_data_i;

  assign en3         = !out_v_q || res_o.ready;
  assign en2         = !s2_v_q || en3;
  assign en1         = !s1_v_q || en2;
  assign pop_ready_o = en1;

  assign sum      = SUM_W'(prod_q) + SUM_W'(s1_start_q);
  assign base_d   = (sum > SUM_W'(ADDR_MAX)) ? ADDR_MAX : sum[ADDR_W-1:0];
  assign addr_raw = (ADDR_W+1)'(base_q) + (ADDR_W+1)'(s2_col_q);
  assign addr_d   = (addr_raw > (ADDR_W+1)'(ADDR_MAX)) ? ADDR_MAX : addr_raw[ADDR_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (en1) s1_v_q  <= pop_valid_i;
      if (en2) s2_v_q  <= s1_v_q;
      if (en3) out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) begin
      prod_q     <= PROD_W'(in_row) * PROD_W'(in_bw);
      s1_start_q <= in_start;
      s1_col_q   <= in_col;
      s1_pix_q   <= in_pix;
    end
    if (en2) begin
      base_q   <= base_d;
      s2_col_q <= s1_col_q;
      s2_pix_q <= s1_pix_q;
    end
    if (en3) begin
      addr_q    <= addr_d;
      oob_q     <= AREA_W'(addr_raw) >= cfg_i.area;
      out_pix_q <= s2_pix_q;
    end
  end

  assign res_o.valid         = out_v_q;
  assign res_o.pixel_address = addr_q;
  assign res_o.low_byte      = out_pix_q[7:0] & BYTE_MASK;
  assign res_o.high_byte     = out_pix_q[15:8];
  assign res_o.out_of_bounds = oob_q;

endmodule

[design/sliced_raw_pixel_address_walker.sv]
// Sliced raw pixel address walker: takes one raw pixel beat per clock and returns its
// frame-buffer pixel index, its two little-endian bytes and an out-of-bounds flag. The
// cursor front end updates once per beat: one beat per cycle while the queue has room
// and no reload is pending. A result passes the queue, row-base multiply, saturation
// and column add registers. The cycle after a write to image_width, slice_count or
// slice_width_0 takes no beat while the current slice width reloads. No clearing pass.
// Depends on srpaw_pkg, srpaw_if, srpaw_cfg, srpaw_front, srpaw_queue and srpaw_back.
`timescale 1ns / 1ps

module sliced_raw_pixel_address_walker #(
  parameter int MAX_SLICES = 4,
  parameter int DIM_BITS   = 13
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [srpaw_pkg::IDX_W-1:0] cfg_idx_i,
  input  logic [srpaw_pkg::DIM_W-1:0] cfg_wdata_i,
  srpaw_in_if.sink                    pix_i,
  srpaw_out_if.source                 res_o
);
  import srpaw_pkg::*;

  localparam int ROW_W  = (DIM_BITS < DIM_W) ? DIM_BITS : DIM_W;
  localparam int ITEM_W = PIX_W + ROW_W + DIM_W + START_W + DIM_W;

  cfg_t                             cfg;
  logic [MAX_SLICES-1:0][DIM_W-1:0] widths;
  logic                             push_valid, push_ready, pop_valid, pop_ready;
  logic [ITEM_W-1:0]                push_data, pop_data;

  srpaw_cfg #(
    .MAX_SLICES(MAX_SLICES),
    .DIM_BITS  (DIM_BITS)
  ) u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg),
    .widths_o   (widths)
  );

  srpaw_front #(
    .MAX_SLICES(MAX_SLICES),
    .ROW_W     (ROW_W),
    .ITEM_W    (ITEM_W)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .widths_i    (widths),
    .pix_i       (pix_i),
    .push_valid_o(push_valid),
    .push_ready_i(push_ready),
    .push_data_o (push_data)
  );

  srpaw_queue #(
    .WIDTH(ITEM_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_data_i (push_data),
    .pop_valid_o (pop_valid),
    .pop_ready_i (pop_ready),
    .pop_data_o  (pop_data)
  );

  srpaw_back #(
    .ROW_W (ROW_W),
    .ITEM_W(ITEM_W)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pop_valid_i(pop_valid),
    .pop_ready_o(pop_ready),
    .pop_data_i (pop_data),
    .res_o      (res_o)
  );

endmodule
